// ----- rtl/c3wf_pkg.sv -----
// Shared types and constants of the 3x3 window filter.
// No dependencies; used by every module of the block.
package c3wf_pkg;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 8;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int PROD_W    = 17;
  localparam int ROW_SUM_W = 19;
  localparam int SUM_W     = 20;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int QDEPTH    = 8;

  localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = 11'd7;

  // register index = paddr[4:2]
  localparam logic [2:0] REG_COEF_TOP      = 3'd0;
  localparam logic [2:0] REG_COEF_MID      = 3'd1;
  localparam logic [2:0] REG_COEF_BOTTOM   = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_end;
  } res_t;

  typedef struct packed {
    logic             produce;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } meta_t;

  // index row*3+col, column 2 newest
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef logic [2:0][COEF_ROW_W-1:0] coef_t;

endpackage

// ----- rtl/c3wf_linebuf.sv -----
// Line store memory and 3x3 window register of the window filter.
// Depends on c3wf_pkg.
module c3wf_linebuf #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [CW-1:0]                addr,
  input  logic [c3wf_pkg::PIX_W-1:0]   px,
  input  c3wf_pkg::meta_t              in_meta,
  output logic                         out_valid,
  output c3wf_pkg::meta_t              out_meta,
  output c3wf_pkg::win_t               win
);

  localparam int PW = c3wf_pkg::PIX_W;

  // upper byte: previous row, lower byte: the row before it
  logic [2*PW-1:0] mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_data;
  logic [2*PW-1:0] fwd_data;
  logic [2*PW-1:0] line;
  logic            fwd;

  logic            s1_valid;
  logic [CW-1:0]   s1_addr;
  logic [PW-1:0]   s1_px;
  c3wf_pkg::meta_t s1_meta;

  logic [PW-1:0]   up1;
  logic [PW-1:0]   up2;

  assign line = fwd ? fwd_data : rd_data;
  assign up1  = line[2*PW-1:PW];
  assign up2  = line[PW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= {s1_px, up1};
    end
  end

  // a restart at column 0 on back-to-back beats reads the entry being written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= rd_en && s1_valid && (s1_addr == addr);
    end
    fwd_data <= {s1_px, up1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= rd_en;
      out_valid <= s1_valid;
    end
    if (rd_en) begin
      s1_addr <= addr;
      s1_px   <= px;
      s1_meta <= in_meta;
    end
    out_meta <= s1_meta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]     <= win[k*3+1];
        win[k*3 + 1] <= win[k*3+2];
      end
      win[2] <= up2;
      win[5] <= up1;
      win[8] <= s1_px;
    end
  end

endmodule

// ----- rtl/c3wf_mac.sv -----
// Nine multiplies and a two-level adder tree over the 3x3 window.
// Depends on c3wf_pkg.
module c3wf_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  c3wf_pkg::meta_t       in_meta,
  input  c3wf_pkg::win_t        win,
  input  c3wf_pkg::coef_t       coef,
  output logic                  out_valid,
  output c3wf_pkg::meta_t       out_meta,
  output logic signed [c3wf_pkg::SUM_W-1:0] sum
);

  localparam int PRW = c3wf_pkg::PROD_W;
  localparam int RSW = c3wf_pkg::ROW_SUM_W;
  localparam int SW  = c3wf_pkg::SUM_W;
  localparam int CFW = c3wf_pkg::COEF_W;

  logic signed [PRW-1:0] prod [9];
  logic signed [RSW-1:0] rsum [3];
  logic                  v1;
  logic                  v2;
  c3wf_pkg::meta_t       m1;
  c3wf_pkg::meta_t       m2;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        prod[k*3+l] <= $signed({1'b0, win[k*3+l]}) * $signed(coef[k][CFW*l +: CFW]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      rsum[k] <= RSW'(prod[k*3]) + RSW'(prod[k*3+1]) + RSW'(prod[k*3+2]);
    end
    sum <= SW'(rsum[0]) + SW'(rsum[1]) + SW'(rsum[2]);
    m1       <= in_meta;
    m2       <= m1;
    out_meta <= m2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ----- rtl/c3wf_outq.sv -----
// Result queue that decouples the filter pipeline from the output handshake.
// Depends on c3wf_pkg.
module c3wf_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  c3wf_pkg::res_t  push_data,
  output logic            res_valid,
  input  logic            res_ready,
  output c3wf_pkg::res_t  res
);

  localparam int D  = c3wf_pkg::QDEPTH;
  localparam int AW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  c3wf_pkg::res_t slots [D];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           pop;

  assign res_valid = (count != '0);
  assign res       = slots[rd_ptr];
  assign pop       = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(D - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(D - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

// ----- rtl/conv3x3_window_filter_core.sv -----
// 3x3 correlation filter over a raster pixel stream. Takes one pixel per clock
// while pix_ready is high and gives at most one result per clock. Both previous
// rows sit in one MAX_WIDTH-entry, 16-bit memory that is read the cycle a pixel
// is accepted and written back the next cycle. Pixels that cause no result
// (border, out-of-size) still pass the pipeline. pix_ready drops only when the
// 8-entry result queue could be overfilled by the pixels in flight, i.e. when
// res_ready stays low. The line store is not cleared at reset: the first two
// rows of a frame fill it before any result uses it.
module conv3x3_window_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  c3wf_pkg::pix_t       pix,
  output logic                 res_valid,
  input  logic                 res_ready,
  output c3wf_pkg::res_t       res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PNW = $clog2(c3wf_pkg::QDEPTH + 1);
  localparam int CRW = c3wf_pkg::COEF_ROW_W;
  localparam int SZW = c3wf_pkg::SIZE_W;
  localparam int POW = c3wf_pkg::POS_W;

  // configuration
  logic [CRW-1:0] coef_top;
  logic [CRW-1:0] coef_mid;
  logic [CRW-1:0] coef_bottom;
  logic [SZW-1:0] frame_width;
  logic [SZW-1:0] frame_height;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top     <= '0;
      coef_mid     <= '0;
      coef_bottom  <= '0;
      frame_width  <= c3wf_pkg::FRAME_SIZE_RESET;
      frame_height <= c3wf_pkg::FRAME_SIZE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        c3wf_pkg::REG_COEF_TOP:     coef_top     <= pwdata[CRW-1:0];
        c3wf_pkg::REG_COEF_MID:     coef_mid     <= pwdata[CRW-1:0];
        c3wf_pkg::REG_COEF_BOTTOM:  coef_bottom  <= pwdata[CRW-1:0];
        c3wf_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[SZW-1:0];
        c3wf_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[SZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      c3wf_pkg::REG_COEF_TOP:     prdata = 32'(coef_top);
      c3wf_pkg::REG_COEF_MID:     prdata = 32'(coef_mid);
      c3wf_pkg::REG_COEF_BOTTOM:  prdata = 32'(coef_bottom);
      c3wf_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      c3wf_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                    prdata = '0;
    endcase
  end

  // sizes in use, clamped to 3..MAX
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (frame_width < SZW'(3)) begin
      w = WW'(3);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height < SZW'(3)) begin
      h = HW'(3);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end
  end

  // raster position
  logic [CW-1:0]   col_count;
  logic [RW-1:0]   row_count;
  logic [CW-1:0]   col_count_next;
  logic [RW-1:0]   row_count_next;
  logic [CW-1:0]   c;
  logic [RW-1:0]   r;
  logic            accept;
  c3wf_pkg::meta_t meta;

  assign accept = pix_valid && pix_ready;
  assign c      = pix.frame_start ? '0 : col_count;
  assign r      = pix.frame_start ? '0 : row_count;

  always_comb begin
    if (WW'(c) >= w - WW'(1)) begin
      col_count_next = '0;
      row_count_next = (HW'(r) >= h - HW'(1)) ? '0 : r + RW'(1);
    end else begin
      col_count_next = c + CW'(1);
      row_count_next = r;
    end
    meta.produce   = (r >= RW'(2)) && (c >= CW'(2)) && (WW'(c) < w) && (HW'(r) < h);
    meta.row       = POW'(r - RW'(2));
    meta.col       = POW'(c - CW'(2));
    meta.frame_end = (HW'(r) == h - HW'(1)) && (WW'(c) == w - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // datapath
  logic                    win_valid;
  c3wf_pkg::meta_t         win_meta;
  c3wf_pkg::win_t          win;
  logic                    mac_valid;
  c3wf_pkg::meta_t         mac_meta;
  logic signed [c3wf_pkg::SUM_W-1:0] mac_sum;
  c3wf_pkg::coef_t         coef;
  c3wf_pkg::res_t          push_data;
  logic                    push;
  logic                    drop;

  assign coef = {coef_bottom, coef_mid, coef_top};

  c3wf_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_linebuf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .addr      (c),
    .px        (pix.pixel),
    .in_meta   (meta),
    .out_valid (win_valid),
    .out_meta  (win_meta),
    .win       (win)
  );

  c3wf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_meta   (win_meta),
    .win       (win),
    .coef      (coef),
    .out_valid (mac_valid),
    .out_meta  (mac_meta),
    .sum       (mac_sum)
  );

  assign push = mac_valid && mac_meta.produce;
  assign drop = mac_valid && !mac_meta.produce;

  assign push_data.filtered  = mac_sum;
  assign push_data.out_row   = mac_meta.row;
  assign push_data.out_col   = mac_meta.col;
  assign push_data.frame_end = mac_meta.frame_end;

  c3wf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // items in flight plus queued results; never more than the queue holds
  logic [PNW-1:0] pending;
  logic [PNW-1:0] pending_next;
  logic           pop;

  assign pop          = res_valid && res_ready;
  assign pending_next = pending + PNW'(accept) - PNW'(drop) - PNW'(pop);
  assign pix_ready    = (pending < PNW'(c3wf_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

endmodule

// ----- rtl/c3wf_checker.sv -----
// Port-level checks of the window filter, bound to the top level.
// Depends on c3wf_pkg and conv3x3_window_filter_core.
module c3wf_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_ready,
  input  logic           res_valid,
  input  logic           res_ready,
  input  c3wf_pkg::res_t res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic [31:0]    prdata,
  input  logic           pready
);

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed or vanished");

  // input back-pressure only while results wait at the output
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> res_valid)
    else $error("input stalled with no result waiting");

  a_coef_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready
      && (paddr[4:2] == c3wf_pkg::REG_COEF_TOP || paddr[4:2] == c3wf_pkg::REG_COEF_MID
          || paddr[4:2] == c3wf_pkg::REG_COEF_BOTTOM))
    ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == {8'b0, $past(pwdata[23:0])})
    else $error("coefficient readback mismatch");

endmodule

bind conv3x3_window_filter_core c3wf_checker u_c3wf_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for conv3x3_window_filter_core: random pixel frames in, filtered windows
// checked against an in-bench window model. Depends only on c3wf_pkg and the core module.
module testbench;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PIXELS  = 380;
  localparam int PRINT_LIMIT    = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pix_valid = 1'b0;
  logic        pix_ready;
  c3wf_pkg::pix_t pix = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  c3wf_pkg::res_t res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // window model state and register shadow
  logic [7:0]  line_prev  [MAX_W] = '{default: 8'h00};
  logic [7:0]  line_prev2 [MAX_W] = '{default: 8'h00};
  logic [7:0]  win_px [9] = '{default: 8'h00};
  int          row_pos = 0;
  int          col_pos = 0;
  logic [23:0] coef_rows [3] = '{default: 24'h0};
  logic [10:0] width_reg = c3wf_pkg::FRAME_SIZE_RESET;
  logic [10:0] height_reg = c3wf_pkg::FRAME_SIZE_RESET;

  c3wf_pkg::pix_t pixel_feed[$];
  c3wf_pkg::res_t pending_windows[$];

  int idle_mode = 0;
  int stall_reqs = 0;
  int stall_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int pixels_in = 0;
  int pixels_queued = 0;
  int windows_checked = 0;
  int settings_applied = 0;

  conv3x3_window_filter_core #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
    .clk, .rst, .pix_valid, .pix_ready, .pix, .res_valid, .res_ready, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_size(logic [10:0] v, int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Slide the window by one pixel and queue the weighted sum when it lies inside the frame.
  function automatic void filter_pixel(c3wf_pkg::pix_t p);
    int w, h, r, c, sum;
    logic [7:0] up2, up1;
    logic signed [7:0] cf;
    c3wf_pkg::res_t want;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    if (p.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    up2 = line_prev2[c];
    up1 = line_prev[c];
    line_prev2[c] = up1;
    line_prev[c] = p.pixel;
    for (int k = 0; k < 3; k++) begin
      win_px[3*k]   = win_px[3*k+1];
      win_px[3*k+1] = win_px[3*k+2];
    end
    win_px[2] = up2;
    win_px[5] = up1;
    win_px[8] = p.pixel;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          cf = coef_rows[k][8*l +: 8];
          sum += int'(win_px[3*k+l]) * int'(cf);
        end
      end
      want.filtered  = sum[19:0];
      want.out_row   = 10'(r - 2);
      want.out_col   = 10'(c - 2);
      want.frame_end = (r == h - 1) && (c == w - 1);
      pending_windows.push_back(want);
    end
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic bit idles_now(bit receiver);
    int pct;
    pct = 0;
    if (idle_mode == 3) pct = 28;
    else if (idle_mode == (receiver ? 2 : 1)) pct = 60;
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_result(c3wf_pkg::res_t got);
    c3wf_pkg::res_t want;
    windows_checked++;
    if (pending_windows.size() == 0) begin
      report_mismatch($sformatf("result with no window pending: %p", got));
    end else begin
      want = pending_windows.pop_front();
      if (got.filtered !== want.filtered)
        report_mismatch($sformatf("filtered at (%0d,%0d): got %0d want %0d",
                                  want.out_row, want.out_col, got.filtered, want.filtered));
      if (got.out_row !== want.out_row)
        report_mismatch($sformatf("out_row: got %0d want %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
        report_mismatch($sformatf("out_col: got %0d want %0d", got.out_col, want.out_col));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end at (%0d,%0d): got %b want %b",
                                  want.out_row, want.out_col, got.frame_end, want.frame_end));
    end
  endtask

  // pixel driver: hold the beat until accepted, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && pix_ready) begin
        filter_pixel(pix);
        pixels_in++;
      end
      if (!pix_valid || pix_ready) begin
        if (pixel_feed.size() != 0 && !idles_now(1'b0)) begin
          pix <= pixel_feed.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_valid && res_ready) check_result(res);
      if (stall_done != stall_reqs) begin
        stall_done <= stall_done + 1;
        hold_left <= HOLD_CYCLES;
        res_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= !idles_now(1'b1);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d windows outstanding",
               WATCHDOG_LIMIT, pending_windows.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      c3wf_pkg::REG_COEF_TOP:     coef_rows[0] = data[23:0];
      c3wf_pkg::REG_COEF_MID:     coef_rows[1] = data[23:0];
      c3wf_pkg::REG_COEF_BOTTOM:  coef_rows[2] = data[23:0];
      c3wf_pkg::REG_FRAME_WIDTH:  width_reg = data[10:0];
      c3wf_pkg::REG_FRAME_HEIGHT: height_reg = data[10:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_filter(logic [23:0] top, logic [23:0] mid, logic [23:0] bottom,
                            logic [10:0] wreg, logic [10:0] hreg);
    write_reg(c3wf_pkg::REG_COEF_TOP, 32'(top));
    write_reg(c3wf_pkg::REG_COEF_MID, 32'(mid));
    write_reg(c3wf_pkg::REG_COEF_BOTTOM, 32'(bottom));
    write_reg(c3wf_pkg::REG_FRAME_WIDTH, 32'(wreg));
    write_reg(c3wf_pkg::REG_FRAME_HEIGHT, 32'(hreg));
    settings_applied++;
  endtask

  function automatic logic [23:0] rand_coef_row();
    case ($urandom_range(5))
      0:       return 24'h808080;
      1:       return 24'h7F7F7F;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [10:0] rand_size_reg();
    if ($urandom_range(9) == 0) return 11'($urandom_range(2));
    return 11'($urandom_range(3, 9));
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic push_pixel(logic [7:0] value, bit mark);
    c3wf_pkg::pix_t item;
    item.pixel = value;
    item.frame_start = mark;
    pixel_feed.push_back(item);
    pixels_queued++;
  endtask

  task automatic queue_pixels(int count, bit mark);
    for (int i = 0; i < count; i++) push_pixel(rand_pixel(), mark && i == 0);
  endtask

  // wait out the stream, then give the pipeline time for border pixels still in flight
  task automatic drain();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || pix_valid || pending_windows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int w, h, n, cut, phase, random_from;
    logic [10:0] wreg, hreg;
    bit mark;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sizes below the minimum clamp to 3x3; all -128 on a white frame hits the low end.
    set_filter(24'h808080, 24'h808080, 24'h808080, 11'd2, 11'd0);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
    drain();
    // High end, and the frame follows without a start mark.
    write_reg(c3wf_pkg::REG_COEF_TOP, 32'h7F7F7F);
    write_reg(c3wf_pkg::REG_COEF_MID, 32'h7F7F7F);
    write_reg(c3wf_pkg::REG_COEF_BOTTOM, 32'h7F7F7F);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, 1'b0);
    drain();
    // Distinct mixed-sign taps catch a flipped or transposed kernel.
    set_filter(24'h030201, 24'hFA05FC, 24'h09F807, 11'd3, 11'd3);
    for (int i = 0; i < 9; i++) push_pixel(8'(i * 29 + 3), i == 0);
    drain();

    // Hold the output long enough to back up the input, then pause until empty.
    set_filter(rand_coef_row(), rand_coef_row(), rand_coef_row(), 11'd5, 11'd5);
    idle_mode = 0;
    queue_pixels(50, 1'b1);
    stall_reqs++;
    drain();
    queue_pixels(25, 1'b0);
    queue_pixels(25, 1'b0);
    drain();

    random_from = pixels_queued;
    phase = 0;
    while (pixels_queued - random_from < RANDOM_PIXELS) begin
      idle_mode = phase % 4;
      wreg = rand_size_reg();
      hreg = rand_size_reg();
      set_filter(rand_coef_row(), rand_coef_row(), rand_coef_row(), wreg, hreg);
      w = clamp_size(wreg, MAX_W);
      h = clamp_size(hreg, MAX_H);
      n = $urandom_range(1, 4);
      mark = 1'b1;
      for (int f = 0; f < n; f++) begin
        if ($urandom_range(4) == 0) begin
          // broken frame: cut short, next one restarts on its mark
          queue_pixels($urandom_range(1, w * h - 1), mark);
          mark = 1'b1;
        end else begin
          queue_pixels(w * h, mark);
          mark = $urandom_range(1);
        end
      end
      if (phase % 5 == 4) begin
        // stop inside the frame, shrink the size, and carry on without a mark
        cut = $urandom_range(2 * w + 1, w * h - 1);
        queue_pixels(cut, mark);
        drain();
        wreg = 11'($urandom_range(3, w));
        hreg = 11'($urandom_range(3, h));
        write_reg(c3wf_pkg::REG_FRAME_WIDTH, 32'(wreg));
        write_reg(c3wf_pkg::REG_FRAME_HEIGHT, 32'(hreg));
        settings_applied++;
        queue_pixels(int'(wreg) * int'(hreg) + 3, 1'b0);
      end
      drain();
      phase++;
    end

    // Oversized size registers clamp to the largest frame: no early wrap of column or row.
    idle_mode = 3;
    set_filter(rand_coef_row(), rand_coef_row(), rand_coef_row(), 11'h7FF, 11'd3);
    queue_pixels(64, 1'b1);
    drain();
    idle_mode = 2;
    set_filter(rand_coef_row(), rand_coef_row(), rand_coef_row(), 11'd3, 11'h7FF);
    queue_pixels(3 * 12, 1'b1);
    drain();

    $display("Checked %0d filtered windows from %0d pixels over %0d register settings,",
             windows_checked, pixels_in, settings_applied);
    $display("with clamped and oversized sizes, mid-frame shrinks and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- conv3x3_window_filter_core.f -----
rtl/c3wf_pkg.sv
rtl/c3wf_linebuf.sv
rtl/c3wf_mac.sv
rtl/c3wf_outq.sv
rtl/conv3x3_window_filter_core.sv
rtl/c3wf_checker.sv
tb/sv/testbench.sv
